### sv/write_footprint_bitmap_counter_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef WRITE_FOOTPRINT_BITMAP_COUNTER_MACROS_SVH
`define WRITE_FOOTPRINT_BITMAP_COUNTER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define WFBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define WFBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/wfbc_pkg.sv
package wfbc_pkg;

   // Request and result field widths.
   localparam int BLOCK_ADDR_BITS = 20;
   localparam int LEN_BITS        = 13;
   localparam int NEW_BITS        = 13;
   localparam int FOOT_BITS       = 21;
   localparam int VOL_BITS        = 40;

   // Longest request that is honored; longer ones are clamped.
   localparam int MAX_REQ_BLOCKS  = 4096;

   // Bitmap organization: one bit per block, packed into memory words.
   localparam int MAP_WORD_BITS   = 32;
   localparam int BIT_IDX_BITS    = $clog2(MAP_WORD_BITS);
   localparam int WORD_ADDR_BITS  = BLOCK_ADDR_BITS - BIT_IDX_BITS;
   localparam int MAP_WORDS       = (2 ** BLOCK_ADDR_BITS) / MAP_WORD_BITS;

   // Block number one past the end of a request; one spare bit for the carry.
   localparam int END_BITS        = BLOCK_ADDR_BITS + 1;

endpackage

### sv/wfbc_ram.sv
module wfbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/write_footprint_bitmap_counter.sv
// Channel | Dir | Handshake       | Fields
// --------+-----+-----------------+-----------------------------------------------------
// req     | in  | req_valid/stall | is_write, start_block, block_count
// rsp     | out | rsp_valid/stall | new_blocks, footprint_total, volume_total, out_of_range
//
// A write that touches W bitmap words steps from one accepted request to the next
// through accept, one word read per cycle, final write-back and result load; a read or
// an empty write steps through accept and result load. W is at most 129, set by the
// 4096-block length clamp and the 32-bit bitmap word. After reset the bitmap memory is
// cleared one word per cycle, during which req_stall stays high. A stalled result is
// held in the output register while the next request is processed; the block waits
// only when a second result is ready.
module write_footprint_bitmap_counter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_is_write,
   input  logic [wfbc_pkg::BLOCK_ADDR_BITS-1:0]  req_start_block,
   input  logic [wfbc_pkg::LEN_BITS-1:0]         req_block_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [wfbc_pkg::NEW_BITS-1:0]         rsp_new_blocks,
   output logic [wfbc_pkg::FOOT_BITS-1:0]        rsp_footprint_total,
   output logic [wfbc_pkg::VOL_BITS-1:0]         rsp_volume_total,
   output logic                                  rsp_out_of_range
);

   import wfbc_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [WORD_ADDR_BITS-1:0] LAST_WORD = WORD_ADDR_BITS'(MAP_WORDS - 1);
   localparam logic [LEN_BITS-1:0]       MAX_LEN   = LEN_BITS'(MAX_REQ_BLOCKS);
   localparam logic [END_BITS-1:0]       MAP_END   = END_BITS'(2 ** BLOCK_ADDR_BITS);
   localparam logic [BIT_IDX_BITS-1:0]   TOP_BIT   = BIT_IDX_BITS'(MAP_WORD_BITS - 1);

   // Control state.
   logic [2:0]                state_ff, state_in;
   logic [WORD_ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                      pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FOOT_BITS-1:0]      foot_ff, foot_in;
   logic [VOL_BITS-1:0]       vol_ff, vol_in;

   // Per-request working registers.
   logic [WORD_ADDR_BITS-1:0] cur_ff, cur_in;
   logic [WORD_ADDR_BITS-1:0] first_ff, first_in;
   logic [WORD_ADDR_BITS-1:0] last_ff, last_in;
   logic [BIT_IDX_BITS-1:0]   lo_ff, lo_in;
   logic [BIT_IDX_BITS-1:0]   hi_ff, hi_in;
   logic [LEN_BITS-1:0]       len_ff, len_in;
   logic                      oor_ff, oor_in;
   logic [NEW_BITS-1:0]       fresh_ff, fresh_in;
   logic [WORD_ADDR_BITS-1:0] pend_addr_ff, pend_addr_in;
   logic [MAP_WORD_BITS-1:0]  pend_mask_ff, pend_mask_in;

   // Result register.
   logic [NEW_BITS-1:0]       out_new_ff, out_new_in;
   logic [FOOT_BITS-1:0]      out_foot_ff, out_foot_in;
   logic [VOL_BITS-1:0]       out_vol_ff, out_vol_in;
   logic                      out_oor_ff, out_oor_in;

   // Memory port signals.
   logic                      ram_wr_en;
   logic [WORD_ADDR_BITS-1:0] ram_wr_addr;
   logic [MAP_WORD_BITS-1:0]  ram_wr_data;
   logic                      ram_rd_en;
   logic [MAP_WORD_BITS-1:0]  ram_rd_data;

   // Request decode and per-word helpers.
   logic                      req_xfer;
   logic                      rsp_load;
   logic                      len_over;
   logic [LEN_BITS-1:0]       len_clamp;
   logic [END_BITS-1:0]       end_raw;
   logic                      end_past;
   logic [END_BITS-1:0]       end_clamp;
   logic [BLOCK_ADDR_BITS-1:0] last_blk;
   logic [BIT_IDX_BITS-1:0]   word_lo;
   logic [BIT_IDX_BITS-1:0]   word_hi;
   logic [MAP_WORD_BITS-1:0]  word_mask;
   logic [NEW_BITS-1:0]       word_fresh;
   logic [FOOT_BITS:0]        foot_sum;
   logic [VOL_BITS:0]         vol_sum;

   function automatic logic [NEW_BITS-1:0] pop_count(input logic [MAP_WORD_BITS-1:0] v);
      logic [NEW_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         n = n + NEW_BITS'(v[i]);
      end
      return n;
   endfunction

   wfbc_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cur_ff),
      .rd_data (ram_rd_data)
   );

   // Handshakes.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Length clamp and the block range that lies inside the bitmap.
   always_comb begin
      len_over  = (req_block_count > MAX_LEN);
      len_clamp = len_over ? MAX_LEN : req_block_count;
      end_raw   = END_BITS'(req_start_block) + END_BITS'(len_clamp);
      end_past  = (end_raw > MAP_END);
      end_clamp = end_past ? MAP_END : end_raw;
      last_blk  = BLOCK_ADDR_BITS'(end_clamp - END_BITS'(1));
   end

   // Bit mask of the current word: trimmed at the first and last word of the range.
   always_comb begin
      word_lo   = (cur_ff == first_ff) ? lo_ff : '0;
      word_hi   = (cur_ff == last_ff) ? hi_ff : TOP_BIT;
      word_mask = ({MAP_WORD_BITS{1'b1}} << word_lo) &
                  ({MAP_WORD_BITS{1'b1}} >> (TOP_BIT - word_hi));
   end

   // Read-modify-write: data read last cycle is merged and written back now. Words of
   // one request are distinct and the last write-back ends before the next request is
   // taken, so a read never needs data that is still being written.
   always_comb begin
      word_fresh  = pop_count(pend_mask_ff & ~ram_rd_data);
      ram_rd_en   = (state_ff == ST_RUN);
      ram_wr_en   = (state_ff == ST_CLEAR) || pend_ff;
      ram_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : pend_addr_ff;
      ram_wr_data = (state_ff == ST_CLEAR) ? '0 : (ram_rd_data | pend_mask_ff);
   end

   // Saturating running totals.
   always_comb begin
      foot_sum = {1'b0, foot_ff} + (FOOT_BITS + 1)'(fresh_ff);
      vol_sum  = {1'b0, vol_ff} + (VOL_BITS + 1)'(len_ff);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      pend_in      = 1'b0;
      pend_addr_in = cur_ff;
      pend_mask_in = word_mask;
      cur_in       = cur_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      len_in       = len_ff;
      oor_in       = oor_ff;
      fresh_in     = pend_ff ? (fresh_ff + word_fresh) : fresh_ff;
      foot_in      = foot_ff;
      vol_in       = vol_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_new_in   = out_new_ff;
      out_foot_in  = out_foot_ff;
      out_vol_in   = out_vol_ff;
      out_oor_in   = out_oor_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + WORD_ADDR_BITS'(1);
            if (clr_addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               len_in   = len_clamp;
               fresh_in = '0;
               first_in = req_start_block[BLOCK_ADDR_BITS-1:BIT_IDX_BITS];
               cur_in   = req_start_block[BLOCK_ADDR_BITS-1:BIT_IDX_BITS];
               last_in  = last_blk[BLOCK_ADDR_BITS-1:BIT_IDX_BITS];
               lo_in    = req_start_block[BIT_IDX_BITS-1:0];
               hi_in    = last_blk[BIT_IDX_BITS-1:0];
               if (req_is_write) begin
                  oor_in   = len_over || end_past;
                  state_in = (len_clamp != '0) ? ST_RUN : ST_DONE;
               end else begin
                  oor_in   = len_over;
                  state_in = ST_DONE;
               end
            end
         end
         ST_RUN: begin
            pend_in = 1'b1;
            if (cur_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               cur_in = cur_ff + WORD_ADDR_BITS'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               foot_in      = foot_sum[FOOT_BITS] ? '1 : foot_sum[FOOT_BITS-1:0];
               vol_in       = vol_sum[VOL_BITS] ? '1 : vol_sum[VOL_BITS-1:0];
               out_new_in   = fresh_ff;
               out_foot_in  = foot_sum[FOOT_BITS] ? '1 : foot_sum[FOOT_BITS-1:0];
               out_vol_in   = vol_sum[VOL_BITS] ? '1 : vol_sum[VOL_BITS-1:0];
               out_oor_in   = oor_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         foot_ff      <= '0;
         vol_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         foot_ff      <= foot_in;
         vol_ff       <= vol_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      len_ff       <= len_in;
      oor_ff       <= oor_in;
      fresh_ff     <= fresh_in;
      pend_addr_ff <= pend_addr_in;
      pend_mask_ff <= pend_mask_in;
      out_new_ff   <= out_new_in;
      out_foot_ff  <= out_foot_in;
      out_vol_ff   <= out_vol_in;
      out_oor_ff   <= out_oor_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_new_blocks      = out_new_ff;
   assign rsp_footprint_total = out_foot_ff;
   assign rsp_volume_total    = out_vol_ff;
   assign rsp_out_of_range    = out_oor_ff;

endmodule

### sv/wfbc_checker.sv
`include "write_footprint_bitmap_counter_macros.svh"

module wfbc_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_stall,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [wfbc_pkg::NEW_BITS-1:0]         rsp_new_blocks,
   input  logic [wfbc_pkg::FOOT_BITS-1:0]        rsp_footprint_total,
   input  logic [wfbc_pkg::VOL_BITS-1:0]         rsp_volume_total,
   input  logic                                  rsp_out_of_range
);

   import wfbc_pkg::*;

   // A stalled result stays in place until its transfer.
   `WFBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_new_blocks) && $stable(rsp_footprint_total) &&
      $stable(rsp_volume_total) && $stable(rsp_out_of_range), "stalled result changed")

   // Right after reset the bitmap clear runs: no request taken, no result shown.
   `WFBC_ASSERT_NOW(a_reset_clear, clock, reset, $past(reset),
      req_stall && !rsp_valid, "activity during bitmap clear")

   // New blocks of a write stay within the length clamp and are already part of the footprint.
   `WFBC_ASSERT_NOW(a_new_in_foot, clock, reset, rsp_valid,
      NEW_BITS'(rsp_new_blocks) <= NEW_BITS'(MAX_REQ_BLOCKS) &&
      FOOT_BITS'(rsp_new_blocks) <= rsp_footprint_total, "new blocks exceed footprint")

   // Every written block also counts toward the volume.
   `WFBC_ASSERT_NOW(a_foot_in_vol, clock, reset, rsp_valid,
      VOL_BITS'(rsp_footprint_total) <= rsp_volume_total, "footprint exceeds volume")

endmodule

bind write_footprint_bitmap_counter wfbc_checker u_wfbc_checker (.*);
